// ===== src/assert_macros.svh =====
// Concurrent check helpers. The user module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define HDT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define HDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hdt_pkg.sv =====
package hdt_pkg;

  // Field widths
  localparam int IDENT_W  = 32;
  localparam int ACTION_W = 3;
  localparam int REQ_W    = 8;
  localparam int DIFF_W   = 6;
  localparam int SLOT_W   = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [IDENT_W-1:0]  ident_t;
  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [DIFF_W-1:0]   diff_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // Action codes
  localparam action_t ACT_READ_ID   = 3'd0;
  localparam action_t ACT_READ_SLOT = 3'd1;
  localparam action_t ACT_SET       = 3'd2;
  localparam action_t ACT_INC       = 3'd3;
  localparam action_t ACT_DEC       = 3'd4;

  // Parameter defaults
  localparam int TABLE_SLOTS_DEF        = 4;
  localparam int DEFAULT_DIFFICULTY_DEF = 1;

  // Remainder unit: identity bits consumed per cycle
  localparam int HASH_BITS   = 8;
  localparam int HASH_CYCLES = IDENT_W / HASH_BITS;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_MAX_DIFF = 2'd0;
  localparam diff_t MAX_DIFF_RESET = 6'd28;

endpackage

// ===== src/hdt_req_if.sv =====
interface hdt_req_if;
  logic              valid;
  logic              ready;
  hdt_pkg::action_t  action;
  hdt_pkg::ident_t   ident_word0;
  hdt_pkg::ident_t   ident_word1;
  hdt_pkg::ident_t   ident_word2;
  hdt_pkg::ident_t   ident_word3;
  hdt_pkg::req_t     slot_request;
  hdt_pkg::req_t     new_difficulty;

  modport source (
    output valid, action, ident_word0, ident_word1, ident_word2, ident_word3,
           slot_request, new_difficulty,
    input  ready
  );
  modport sink (
    input  valid, action, ident_word0, ident_word1, ident_word2, ident_word3,
           slot_request, new_difficulty,
    output ready
  );
endinterface

// ===== src/hdt_rsp_if.sv =====
interface hdt_rsp_if;
  logic            valid;
  logic            ready;
  hdt_pkg::slot_t  slot;
  hdt_pkg::diff_t  difficulty;
  logic            rejected;

  modport source (
    output valid, slot, difficulty, rejected,
    input  ready
  );
  modport sink (
    input  valid, slot, difficulty, rejected,
    output ready
  );
endinterface

// ===== src/hashed_difficulty_table_unit.sv =====
// Hashed difficulty table: one puzzle difficulty per slot, kept in a small
// synchronous memory.
// Request channel (in_ch): valid/ready; a transfer carries the action, the
// four identity words, a slot number for read by slot and a new value for set.
// Result channel (out_ch): valid/ready; one result per request with the slot,
// the value read or written (zero when refused) and a reject flag.
// cfg_*: APB write/read of max_difficulty at byte address 0; pready is always
// high. Write it only while no request is in flight.
// One request is in flight at a time: it passes through the remainder unit (one
// identity byte per cycle), then the table read, then the update.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only holds off the update step.
// Reset: every entry reads as DEFAULT_DIFFICULTY (per-entry valid bits are
// cleared, no sweep), max_difficulty returns to 28, both channels go idle.
`include "assert_macros.svh"

module hashed_difficulty_table_unit #(
  parameter int TABLE_SLOTS        = hdt_pkg::TABLE_SLOTS_DEF,
  parameter int DEFAULT_DIFFICULTY = hdt_pkg::DEFAULT_DIFFICULTY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hdt_req_if.sink                    in_ch,
  hdt_rsp_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hdt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hdt_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hdt_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int RW    = $clog2(TABLE_SLOTS) + 1;
  localparam int RW1   = RW + 1;
  localparam int CNT_W = (hdt_pkg::HASH_CYCLES > 1) ? $clog2(hdt_pkg::HASH_CYCLES) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(hdt_pkg::HASH_CYCLES - 1);
  localparam int BYTE_VALS = 2 ** hdt_pkg::HASH_BITS;

  // Residue of each byte value modulo the slot count
  function automatic logic [BYTE_VALS*RW-1:0] byte_res_tbl();
    logic [BYTE_VALS*RW-1:0] t;
    t = '0;
    for (int v = 0; v < BYTE_VALS; v++) begin
      t[v*RW +: RW] = RW'(v % TABLE_SLOTS);
    end
    return t;
  endfunction

  // Residue of each partial remainder after a one-byte shift
  function automatic logic [TABLE_SLOTS*RW-1:0] shift_res_tbl();
    logic [TABLE_SLOTS*RW-1:0] t;
    t = '0;
    for (int r = 0; r < TABLE_SLOTS; r++) begin
      t[r*RW +: RW] = RW'((r * BYTE_VALS) % TABLE_SLOTS);
    end
    return t;
  endfunction

  localparam logic [BYTE_VALS*RW-1:0]   BYTE_TBL  = byte_res_tbl();
  localparam logic [TABLE_SLOTS*RW-1:0] SHIFT_TBL = shift_res_tbl();

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  logic [1:0]            state_r, state_nxt;
  hdt_pkg::action_t      act_r;
  hdt_pkg::req_t         req_r;
  hdt_pkg::req_t         newd_r;
  hdt_pkg::ident_t       h_r;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r;
  hdt_pkg::diff_t        max_r;

  hdt_pkg::diff_t        mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] vld_r;
  hdt_pkg::diff_t        rd_data_r;
  logic                  rd_vld_r;

  logic                  out_valid_r;
  hdt_pkg::slot_t        out_slot_r;
  hdt_pkg::diff_t        out_diff_r;
  logic                  out_rej_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  exec_load;
  logic                  mem_we;
  logic [IDX_W-1:0]      tbl_idx;
  hdt_pkg::ident_t       xw;
  hdt_pkg::diff_t        cur;
  logic [hdt_pkg::REQ_W-1:0] want;
  logic                  is_write;
  logic                  rej;
  hdt_pkg::diff_t        res_val;
  hdt_pkg::slot_t        res_slot;
  logic                  cfg_wr;

  // Request handshake: one request in flight
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_load   = (state_r == ST_EXEC) && out_free;

  // XOR the identity words and fold the upper bytes into the low byte
  always_comb begin
    xw = in_ch.ident_word0 ^ in_ch.ident_word1 ^ in_ch.ident_word2 ^ in_ch.ident_word3;
    xw[7:0] = xw[7:0] ^ xw[31:24] ^ xw[23:16] ^ xw[15:8];
  end

  // Remainder unit: fold in the top hash byte, reduce modulo slots
  always_comb begin : rem_step
    logic [RW-1:0]  sh;
    logic [RW-1:0]  bv;
    logic [RW1-1:0] tw;
    sh = SHIFT_TBL[rem_r[IDX_W-1:0] * RW +: RW];
    bv = BYTE_TBL[h_r[hdt_pkg::IDENT_W-1 -: hdt_pkg::HASH_BITS] * RW +: RW];
    tw = {1'b0, sh} + {1'b0, bv};
    if (tw >= RW1'(TABLE_SLOTS)) begin
      tw = tw - RW1'(TABLE_SLOTS);
    end
    rem_nxt = tw[RW-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_HASH;
      ST_HASH: if (cnt_r == LAST_CNT) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and run the remainder
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_ch.action;
      req_r  <= in_ch.slot_request;
      newd_r <= in_ch.new_difficulty;
      h_r    <= xw;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (state_r == ST_HASH) begin
      h_r   <= h_r << hdt_pkg::HASH_BITS;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Table address: requested slot or hashed slot
  always_comb begin
    if (act_r == hdt_pkg::ACT_READ_SLOT) begin
      tbl_idx  = IDX_W'(req_r);
      res_slot = hdt_pkg::slot_t'(req_r);
    end else begin
      tbl_idx  = IDX_W'(rem_r);
      res_slot = hdt_pkg::slot_t'(rem_r);
    end
  end

  // Table memory: read in ST_READ, write back in ST_EXEC
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tbl_idx] <= res_val;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= mem[tbl_idx];
      rd_vld_r  <= vld_r[tbl_idx];
    end
  end

  // Entries never written read as the default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[tbl_idx] <= 1'b1;
    end
  end

  // Modify: pick the new value and check its range
  always_comb begin
    cur      = rd_vld_r ? rd_data_r : hdt_pkg::diff_t'(DEFAULT_DIFFICULTY);
    want     = '0;
    is_write = 1'b0;
    rej      = 1'b0;
    case (act_r)
      hdt_pkg::ACT_READ_ID: begin
        want = hdt_pkg::REQ_W'(cur);
      end
      hdt_pkg::ACT_READ_SLOT: begin
        want = hdt_pkg::REQ_W'(cur);
        rej  = ({1'b0, req_r} >= 9'(TABLE_SLOTS));
      end
      hdt_pkg::ACT_SET: begin
        want     = newd_r;
        is_write = 1'b1;
      end
      hdt_pkg::ACT_INC: begin
        want     = hdt_pkg::REQ_W'(cur) + 1'b1;
        is_write = 1'b1;
      end
      hdt_pkg::ACT_DEC: begin
        want     = hdt_pkg::REQ_W'(cur) - 1'b1;
        is_write = (cur != '0);
        rej      = (cur == '0);
      end
      default: rej = 1'b1;
    endcase
    if (is_write && (want == '0 || want > hdt_pkg::REQ_W'(max_r))) begin
      rej = 1'b1;
    end
    res_val = rej ? '0 : want[hdt_pkg::DIFF_W-1:0];
  end

  assign mem_we = exec_load && is_write && !rej;

  // Output register: load on update, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_load) begin
      out_slot_r <= res_slot;
      out_diff_r <= res_val;
      out_rej_r  <= rej;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.difficulty = out_diff_r;
  assign out_ch.rejected   = out_rej_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= hdt_pkg::MAX_DIFF_RESET;
    end else if (cfg_wr && cfg_paddr == hdt_pkg::REG_MAX_DIFF) begin
      max_r <= cfg_pwdata[hdt_pkg::DIFF_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == hdt_pkg::REG_MAX_DIFF) ? hdt_pkg::CFG_DW'(max_r) : '0;

  // Checks
  `HDT_ASSERT_NXT(a_accept_starts_hash, in_fire, state_r == ST_HASH, "accepted request did not start hashing")
  `HDT_ASSERT(a_rem_in_range, state_r == ST_READ, rem_r < RW'(TABLE_SLOTS), "hashed slot out of range")
  `HDT_ASSERT(a_write_in_range, mem_we, res_val != '0 && res_val <= max_r, "table write outside 1..max")
  `HDT_ASSERT(a_reject_zero, out_valid_r && out_rej_r, out_diff_r == '0, "refused result carries a value")

endmodule

// ===== bench/difficulty_checker.sv =====
`timescale 1ns / 1ps

module difficulty_checker
  import hdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hdt_req_if                req_mon,
  hdt_rsp_if                rsp_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int unsigned       answers_owed,
  output int unsigned       fault_count
);

  localparam int SLOTS = TABLE_SLOTS_DEF;

  typedef struct packed {
    slot_t slot;
    diff_t difficulty;
    logic  rejected;
  } answer_t;

  // Mirror of the block's table and limit register
  diff_t       slot_values [SLOTS];
  diff_t       max_level;
  answer_t     owed_answers [$];
  int unsigned misses = 0;

  // Hash the identity, apply the action to the mirror, return the answer
  function automatic answer_t settle_request(action_t act, ident_t w0, ident_t w1,
                                             ident_t w2, ident_t w3, req_t sreq,
                                             req_t ndiff);
    logic [31:0] h;
    int unsigned hs;
    int unsigned want;
    diff_t       cur;
    answer_t     a;
    h = w0 ^ w1 ^ w2 ^ w3;
    for (int k = 0; k < 3; k++) begin
      h ^= (h >> (24 - 8 * k)) & 32'hFF;
    end
    hs = h % SLOTS;
    a.slot = slot_t'(hs);
    a.difficulty = '0;
    a.rejected = 1'b1;
    if (act == ACT_READ_SLOT) begin
      a.slot = slot_t'(sreq);
      if (int'(sreq) < SLOTS) begin
        a.difficulty = slot_values[sreq];
        a.rejected = 1'b0;
      end
      return a;
    end
    cur = slot_values[hs];
    case (act)
      ACT_READ_ID: begin
        a.difficulty = cur;
        a.rejected = 1'b0;
        return a;
      end
      ACT_SET: want = ndiff;
      ACT_INC: want = cur + 1;
      ACT_DEC: begin
        if (cur == 0) return a;
        want = cur - 1;
      end
      default: return a;
    endcase
    // Write only values inside 1..max
    if (want >= 1 && want <= max_level) begin
      slot_values[hs] = diff_t'(want);
      a.difficulty = diff_t'(want);
      a.rejected = 1'b0;
    end
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want_a;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_values[i] = diff_t'(DEFAULT_DIFFICULTY_DEF);
      max_level = MAX_DIFF_RESET;
      owed_answers.delete();
    end else begin
      // Track limit register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_MAX_DIFF) begin
        max_level = cfg_pwdata[DIFF_W-1:0];
      end
      // Predict on each request transfer
      if (req_mon.valid && req_mon.ready) begin
        owed_answers.push_back(settle_request(req_mon.action, req_mon.ident_word0,
                                              req_mon.ident_word1, req_mon.ident_word2,
                                              req_mon.ident_word3, req_mon.slot_request,
                                              req_mon.new_difficulty));
      end
      // Compare each result transfer with the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.slot, rsp_mon.difficulty, rsp_mon.rejected};
        if (owed_answers.size() == 0) begin
          $display("%0t: unexpected result: slot %0d difficulty %0d rejected %0b",
                   $time, got.slot, got.difficulty, got.rejected);
          misses++;
        end else begin
          want_a = owed_answers.pop_front();
          if (got !== want_a) begin
            $display("%0t: mismatch: expected slot %0d difficulty %0d rejected %0b, got slot %0d difficulty %0d rejected %0b",
                     $time, want_a.slot, want_a.difficulty, want_a.rejected,
                     got.slot, got.difficulty, got.rejected);
            misses++;
          end
        end
      end
    end
    answers_owed <= owed_answers.size();
    fault_count <= misses;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hdt_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int RANDOM_PER_PHASE = 206;
  localparam int QUIET_CYCLES     = 10;

  typedef struct {
    action_t act;
    ident_t  w0, w1, w2, w3;
    req_t    sreq;
    req_t    ndiff;
  } request_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int unsigned       answers_owed;
  int unsigned       fault_count;
  int unsigned       cycles = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       cur_max = MAX_DIFF_RESET;

  hdt_req_if req_ch ();
  hdt_rsp_if rsp_ch ();

  hashed_difficulty_table_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  difficulty_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .answers_owed (answers_owed),
    .fault_count  (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic request_t make_req(action_t act, ident_t w0, ident_t w1, ident_t w2,
                                        ident_t w3, req_t sreq, req_t ndiff);
    request_t r;
    r.act = act;
    r.w0 = w0;
    r.w1 = w1;
    r.w2 = w2;
    r.w3 = w3;
    r.sreq = sreq;
    r.ndiff = ndiff;
    return r;
  endfunction

  // Present one request, hold until transfer, then idle at the current rate
  task automatic offer(request_t r);
    req_ch.valid <= 1'b1;
    req_ch.action <= r.act;
    req_ch.ident_word0 <= r.w0;
    req_ch.ident_word1 <= r.w1;
    req_ch.ident_word2 <= r.w2;
    req_ch.ident_word3 <= r.w3;
    req_ch.slot_request <= r.sreq;
    req_ch.new_difficulty <= r.ndiff;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain, then write the limit register over the APB port
  task automatic write_max(int unsigned v);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_DIFF;
    cfg_pwdata <= CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cur_max = v;
  endtask

  initial begin
    request_t    directed [$];
    request_t    r;
    int unsigned limits [8];
    int unsigned roll;

    limits = '{63, 1, 17, 0, 40, 3, 63, 28};
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_READ_ID;
    req_ch.ident_word0 <= '0;
    req_ch.ident_word1 <= '0;
    req_ch.ident_word2 <= '0;
    req_ch.ident_word3 <= '0;
    req_ch.slot_request <= '0;
    req_ch.new_difficulty <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity extremes, slot reads in and out of range,
    // value limits, increment past max, decrement to zero, unused codes
    directed.push_back(make_req(ACT_READ_ID, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_READ_ID, '1, '0, '0, '0, 8'd255, 8'd255));
    directed.push_back(make_req(ACT_READ_ID, 32'h1, 32'h0, 32'hA5A5_A5A5, '1, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_READ_ID, 32'h8000_0002, '1, '1, '1, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_READ_SLOT, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_READ_SLOT, '1, '1, '1, '1, 8'd3, 8'd0));
    directed.push_back(make_req(ACT_READ_SLOT, '0, '0, '0, '0, 8'd4, 8'd0));
    directed.push_back(make_req(ACT_READ_SLOT, '0, '0, '0, '0, 8'd255, 8'd0));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd255));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd29));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd28));
    directed.push_back(make_req(ACT_INC, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd1));
    directed.push_back(make_req(ACT_DEC, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_SET, '0, '0, '0, '0, 8'd0, 8'd27));
    directed.push_back(make_req(ACT_INC, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(ACT_DEC, '0, '0, '0, '0, 8'd0, 8'd0));
    directed.push_back(make_req(action_t'(ACT_DEC + 1), '0, '0, '0, '0, 8'd0, 8'd5));
    directed.push_back(make_req(action_t'(ACT_DEC + 2), '1, '0, '0, '0, 8'd1, 8'd5));
    directed.push_back(make_req(action_t'(ACT_DEC + 3), '0, '0, '0, '1, 8'd2, 8'd5));
    directed.push_back(make_req(ACT_READ_SLOT, '0, '0, '0, '0, 8'd0, 8'd0));
    foreach (directed[i]) offer(directed[i]);

    // Random phases: one limit setting and one idling mode each
    for (int p = 0; p < 8; p++) begin
      write_max(limits[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 18) r.act = ACT_READ_ID;
        else if (roll < 32) r.act = ACT_READ_SLOT;
        else if (roll < 57) r.act = ACT_SET;
        else if (roll < 74) r.act = ACT_INC;
        else if (roll < 92) r.act = ACT_DEC;
        else r.act = action_t'(ACT_DEC + $urandom_range(3, 1));
        r.w0 = $urandom;
        r.w1 = $urandom;
        r.w2 = $urandom;
        r.w3 = $urandom;
        // Mostly valid slots and values up to one past the limit, sometimes anything
        if ($urandom_range(99, 0) < 80) r.sreq = req_t'($urandom_range(TABLE_SLOTS_DEF - 1, 0));
        else r.sreq = req_t'($urandom_range(255, 0));
        if ($urandom_range(99, 0) < 75) r.ndiff = req_t'($urandom_range(cur_max + 1, 0));
        else r.ndiff = req_t'($urandom_range(255, 0));
        offer(r);
      end
    end

    // Drain and settle, then give the verdict
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
